### rtl/atm_pkg.sv
// Shared types and constants for the milliradian atan2 block.
// No dependencies.
package atm_pkg;

  localparam int unsigned MagW   = 32;
  localparam int unsigned NarW   = 8;
  localparam int unsigned ProdW  = 2 * NarW;
  localparam int unsigned NumW   = 32;
  localparam int unsigned DenW   = 23;
  localparam int unsigned QuotW  = 10;
  localparam int unsigned AngW   = 13;

  localparam logic [NumW-1:0] NUM_GAIN   = 32'd60937;
  localparam logic [DenW-1:0] DEN_X_GAIN = 23'd61;
  localparam logic [DenW-1:0] DEN_Y_GAIN = 23'd17;
  localparam logic [AngW-1:0] HALF_PI    = 13'd1571;
  localparam logic [AngW-1:0] PI_MRAD    = 13'd3142;
  localparam logic [AngW-1:0] TWO_PI     = 13'd6284;

  typedef struct packed {
    logic swapped;
    logic xneg;
    logic yneg;
    logic zero;
  } flags_t;

endpackage

### rtl/atm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on atm_pkg.
module atm_div import atm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NumW-1:0]  num,
  input  logic [DenW-1:0]  den,
  input  flags_t           in_flags,
  output logic             out_valid,
  output logic [QuotW-1:0] quot,
  output flags_t           out_flags
);

  logic             vld_r  [QuotW];
  logic [NumW-1:0]  rem_r  [QuotW];
  logic [DenW-1:0]  den_r  [QuotW];
  logic [QuotW-1:0] quo_r  [QuotW];
  flags_t           flg_r  [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    localparam int unsigned Bit = QuotW - 1 - k;
    logic             vld_in;
    logic [NumW-1:0]  rem_in;
    logic [DenW-1:0]  den_in;
    logic [QuotW-1:0] quo_in;
    flags_t           flg_in;
    logic [NumW:0]    dsh;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
      assign flg_in = in_flags;
    end else begin : g_next
      assign vld_in = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
      assign flg_in = flg_r[k-1];
    end

    assign dsh = (NumW+1)'({10'd0, den_in}) << Bit;
    assign ge  = {1'b0, rem_in} >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? NumW'({1'b0, rem_in} - dsh) : rem_in;
        den_r[k] <= den_in;
        quo_r[k] <= quo_in | (QuotW'(ge) << Bit);
        flg_r[k] <= flg_in;
      end
    end
  end

  assign out_valid = vld_r[QuotW-1];
  assign quot      = quo_r[QuotW-1];
  assign out_flags = flg_r[QuotW-1];

endmodule

### rtl/atan2_milliradian_approx.sv
// Top level of the milliradian atan2 block: fold, normalise, products, divide, unfold.
// Depends on atm_pkg and atm_div.
//
// Four-quadrant arctangent of (y, x) in milliradians, 0 to 6283, 0 when both
// inputs are zero. One transfer may be accepted every cycle while the output
// is not stalled; each result passes through five front stages, a ten-stage
// divider that resolves one quotient bit per stage, and the output register.
// When the output is stalled the whole pipeline holds.
module atan2_milliradian_approx import atm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] y_coord, [63:32] x_coord
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [12:0] angle_mrad, [15:13] zero
);

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: magnitudes and octant fold
  logic            s1_vld_r;
  logic [MagW-1:0] s1_ax_r, s1_ay_r;
  flags_t          s1_flg_r;
  logic [MagW-1:0] my, mx;
  logic            yn, xn;

  always_comb begin
    yn = in_tdata[31];
    xn = in_tdata[63];
    my = yn ? (MagW'(0) - in_tdata[31:0])  : in_tdata[31:0];
    mx = xn ? (MagW'(0) - in_tdata[63:32]) : in_tdata[63:32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_flg_r.swapped <= my > mx;
      s1_flg_r.xneg    <= xn;
      s1_flg_r.yneg    <= yn;
      s1_flg_r.zero    <= 1'b0;
      s1_ax_r          <= (my > mx) ? my : mx;
      s1_ay_r          <= (my > mx) ? mx : my;
    end
  end

  // stage 2: shift amount from the leading one of the larger magnitude
  logic            s2_vld_r;
  logic [MagW-1:0] s2_ax_r, s2_ay_r;
  logic [4:0]      s2_sh_r;
  flags_t          s2_flg_r;
  logic [4:0]      sh_nxt;

  always_comb begin
    sh_nxt = '0;
    for (int i = NarW; i < MagW; i++) begin
      if (s1_ax_r[i]) sh_nxt = 5'(i - NarW + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ax_r  <= s1_ax_r;
      s2_ay_r  <= s1_ay_r;
      s2_sh_r  <= sh_nxt;
      s2_flg_r <= s1_flg_r;
    end
  end

  // stage 3: apply the shift
  logic            s3_vld_r;
  logic [NarW-1:0] s3_ax_r, s3_ay_r;
  flags_t          s3_flg_r;
  logic [MagW-1:0] ax_sh, ay_sh;

  assign ax_sh = s2_ax_r >> s2_sh_r;
  assign ay_sh = s2_ay_r >> s2_sh_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ax_r  <= ax_sh[NarW-1:0];
      s3_ay_r  <= ay_sh[NarW-1:0];
      s3_flg_r <= {s2_flg_r.swapped, s2_flg_r.xneg, s2_flg_r.yneg,
                   ax_sh[NarW-1:0] == '0};
    end
  end

  // stage 4: narrow products
  logic             s4_vld_r;
  logic [ProdW-1:0] s4_xx_r, s4_yy_r, s4_xy_r;
  flags_t           s4_flg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_xx_r  <= s3_ax_r * s3_ax_r;
      s4_yy_r  <= s3_ay_r * s3_ay_r;
      s4_xy_r  <= s3_ax_r * s3_ay_r;
      s4_flg_r <= s3_flg_r;
    end
  end

  // stage 5: numerator and denominator
  logic            s5_vld_r;
  logic [NumW-1:0] s5_num_r;
  logic [DenW-1:0] s5_den_r;
  flags_t          s5_flg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_num_r <= NumW'({16'd0, s4_xy_r} * NUM_GAIN);
      s5_den_r <= DenW'(DenW'(s4_xx_r) * DEN_X_GAIN + DenW'(s4_yy_r) * DEN_Y_GAIN);
      s5_flg_r <= s4_flg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  logic             dv_vld;
  logic [QuotW-1:0] dv_quot;
  flags_t           dv_flg;

  atm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_vld_r),
    .num       (s5_num_r),
    .den       (s5_den_r),
    .in_flags  (s5_flg_r),
    .out_valid (dv_vld),
    .quot      (dv_quot),
    .out_flags (dv_flg)
  );

  // unfold into the output register
  logic            out_vld_r;
  logic [AngW-1:0] ang_r, ang_nxt;

  always_comb begin
    ang_nxt = AngW'(dv_quot);
    if (dv_flg.swapped) ang_nxt = HALF_PI - ang_nxt;
    if (dv_flg.xneg)    ang_nxt = PI_MRAD - ang_nxt;
    if (dv_flg.yneg && ang_nxt != '0) ang_nxt = TWO_PI - ang_nxt;
    if (dv_flg.zero)    ang_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_r <= ang_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'd0, ang_r};

`ifndef SYNTHESIS
  a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[12:0] <= 13'd6283))
    else $error("angle out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (s5_vld_r == $past(s5_vld_r)))
    else $error("pipeline advanced during stall");
`endif

endmodule
